// ----- rtl/cnsr_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the chord slot note reference counter
// no dependencies

package cnsr_pkg;

  localparam int unsigned NumSlots  = 7;
  localparam int unsigned MaxTones  = 6;
  localparam int unsigned NoteRange = 128;
  localparam int unsigned SnDepth   = NumSlots * MaxTones;

  localparam logic [1:0] OpPress  = 2'd0;
  localparam logic [1:0] OpRelease = 2'd1;
  localparam logic [1:0] OpAllOff = 2'd2;

  localparam logic [1:0] EvNone = 2'd0;
  localparam logic [1:0] EvOn   = 2'd1;
  localparam logic [1:0] EvOff  = 2'd2;

  localparam logic [1:0] RegOctave   = 2'd0;
  localparam logic [1:0] RegVelocity = 2'd1;
  localparam logic [1:0] RegChannel  = 2'd2;
  localparam logic [1:0] RegDegrees  = 2'd3;

  localparam logic [5:0] ClaimMax = 6'd63;

  typedef struct packed {
    logic signed [3:0] octave_shift;
    logic [6:0]        note_velocity;
    logic [4:0]        channel_number;
    logic [2:0]        degree_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] note_number;
    logic [6:0] event_velocity;
    logic [4:0] event_channel;
    logic [6:0] active_slots;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

// ----- rtl/cnsr_in_if.sv -----
`timescale 1ns / 1ps
// input and output channel interfaces
// uses no package

interface cnsr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [2:0]        slot;
  logic [3:0]        root_pitch_class;
  logic [2:0]        tone_count;
  logic signed [6:0] tone_offset_0;
  logic signed [6:0] tone_offset_1;
  logic signed [6:0] tone_offset_2;
  logic signed [6:0] tone_offset_3;
  logic signed [6:0] tone_offset_4;
  logic signed [6:0] tone_offset_5;
  modport source (output valid, opcode, slot, root_pitch_class, tone_count, tone_offset_0,
                  tone_offset_1, tone_offset_2, tone_offset_3, tone_offset_4,
                  tone_offset_5, input ready);
  modport sink (input valid, opcode, slot, root_pitch_class, tone_count, tone_offset_0,
                tone_offset_1, tone_offset_2, tone_offset_3, tone_offset_4,
                tone_offset_5, output ready);
endinterface

interface cnsr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [6:0] note_number;
  logic [6:0] event_velocity;
  logic [4:0] event_channel;
  logic [6:0] active_slots;
  logic       last_result;
  modport source (output valid, event_kind, note_number, event_velocity, event_channel,
                  active_slots, last_result, input ready);
  modport sink (input valid, event_kind, note_number, event_velocity, event_channel,
                active_slots, last_result, output ready);
endinterface

// ----- rtl/cnsr_seq.sv -----
`timescale 1ns / 1ps
// sequencer with the claim counter memory and the slot note memory
// depends on cnsr_pkg and cnsr_in_if

module cnsr_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  cnsr_in_if.sink           in_i,
  input  cnsr_pkg::cfg_t    cfg_i,
  input  logic              out_free_i,
  output cnsr_pkg::push_t   push_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_PRD  = 4'd3;
  localparam logic [3:0] S_PWR  = 4'd4;
  localparam logic [3:0] S_NRD  = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_RWR  = 4'd7;
  localparam logic [3:0] S_SCAN = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_q, state_d;

  // memories
  logic [5:0] claim_mem [cnsr_pkg::NoteRange];
  logic [6:0] sn_mem [cnsr_pkg::SnDepth];
  logic       c_we, c_re, s_we, s_re;
  logic [6:0] c_wa, c_ra, s_wd;
  logic [5:0] c_wd, s_wa, s_ra;
  logic [5:0] crd_q;
  logic [6:0] srd_q;

  always_ff @(posedge clk_i) begin
    if (c_we) claim_mem[c_wa] <= c_wd;
    if (c_re) crd_q <= claim_mem[c_ra];
    if (s_we) sn_mem[s_wa] <= s_wd;
    if (s_re) srd_q <= sn_mem[s_ra];
  end

  // latched item
  logic [1:0]        op_q;
  logic [2:0]        slot_q;
  logic [2:0]        cnt_q, cnt_d;
  logic signed [9:0] root_q;
  logic signed [6:0] off_q [cnsr_pkg::MaxTones];
  logic [2:0]        i_q, i_d;
  logic [7:0]        a_q, a_d;
  logic              p_q, p_d;
  logic [6:0]        held_q, held_d;
  logic [2:0]        tc_q [cnsr_pkg::NumSlots];
  logic [2:0]        tc_d [cnsr_pkg::NumSlots];
  logic              cand_v_q, cand_v_d;
  logic [1:0]        cand_k_q, cand_k_d;
  logic [6:0]        cand_n_q, cand_n_d;

  // reference note and root placement
  logic signed [9:0] oct_w, ref_w, pc_adj, root_c;
  logic [3:0]        pc;
  assign pc     = in_i.root_pitch_class;
  assign oct_w  = {{6{cfg_i.octave_shift[3]}}, cfg_i.octave_shift};
  assign ref_w  = 10'sd60 + (oct_w <<< 3) + (oct_w <<< 2);
  assign pc_adj = (pc <= 4'd6) ? $signed({6'd0, pc}) : $signed({6'd0, pc}) - 10'sd12;
  assign root_c = ref_w + pc_adj;

  logic signed [9:0] sum_c;
  logic [6:0]        note_c;
  always_comb begin
    sum_c = root_q + {{3{off_q[i_q][6]}}, off_q[i_q]};
    if (sum_c < 10'sd0)        note_c = 7'd0;
    else if (sum_c > 10'sd127) note_c = 7'd127;
    else                       note_c = sum_c[6:0];
  end

  logic [5:0] sn_base;
  assign sn_base = ({3'd0, slot_q} << 2) + ({3'd0, slot_q} << 1);

  logic [6:0] vel_c;
  logic [4:0] ch_c;
  assign vel_c = (cfg_i.note_velocity == 7'd0) ? 7'd1 : cfg_i.note_velocity;
  always_comb begin
    if (cfg_i.channel_number == 5'd0)      ch_c = 5'd1;
    else if (cfg_i.channel_number > 5'd16) ch_c = 5'd16;
    else                                   ch_c = cfg_i.channel_number;
  end

  logic [6:0] mask_c;
  always_comb begin
    for (int s = 0; s < cnsr_pkg::NumSlots; s++) mask_c[s] = (tc_q[s] != 3'd0);
  end

  logic       slot_ok;
  assign slot_ok = ({29'd0, slot_q} < cnsr_pkg::NumSlots);

  logic [2:0] cnt_in;
  assign cnt_in = (in_i.tone_count > 3'd6) ? 3'd6 : in_i.tone_count;

  // event found in the current step
  logic       have_ev, blocked;
  logic [1:0] ev_k;
  logic [6:0] ev_n;
  logic [5:0] dec_c;
  assign dec_c = (crd_q == 6'd0) ? 6'd0 : crd_q - 6'd1;

  always_comb begin
    have_ev = 1'b0;
    ev_k    = cnsr_pkg::EvNone;
    ev_n    = 7'd0;
    unique case (state_q)
      S_PWR: begin
        have_ev = (crd_q == 6'd0);
        ev_k    = cnsr_pkg::EvOn;
        ev_n    = note_c;
      end
      S_RWR: begin
        have_ev = (dec_c == 6'd0);
        ev_k    = cnsr_pkg::EvOff;
        ev_n    = srd_q;
      end
      S_SCAN: begin
        have_ev = p_q && (crd_q != 6'd0);
        ev_k    = cnsr_pkg::EvOff;
        ev_n    = a_q[6:0] - 7'd1;
      end
      default: ;
    endcase
  end
  assign blocked = have_ev && cand_v_q && !out_free_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    a_d      = a_q;
    p_d      = p_q;
    held_d   = held_q;
    tc_d     = tc_q;
    cand_v_d = cand_v_q;
    cand_k_d = cand_k_q;
    cand_n_d = cand_n_q;
    c_we = 1'b0; c_wa = 7'd0; c_wd = 6'd0;
    c_re = 1'b0; c_ra = 7'd0;
    s_we = 1'b0; s_wa = 6'd0; s_wd = 7'd0;
    s_re = 1'b0; s_ra = 6'd0;
    push_o = '0;
    in_i.ready = (state_q == S_IDLE);

    // candidate holds the newest event so the final one can be flagged
    if (have_ev && !blocked) begin
      if (cand_v_q) begin
        push_o.valid = 1'b1;
        push_o.res   = '{cand_k_q, cand_n_q, (cand_k_q == cnsr_pkg::EvOn) ? vel_c : 7'd0,
                         (op_q == cnsr_pkg::OpAllOff) ? 5'd1 : ch_c, mask_c, 1'b0};
      end
      cand_v_d = 1'b1;
      cand_k_d = ev_k;
      cand_n_d = ev_n;
    end

    unique case (state_q)
      S_CLR: begin
        c_we = 1'b1;
        c_wa = a_q[6:0];
        a_d  = a_q + 8'd1;
        if (a_q[6:0] == 7'd127) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          cnt_d   = cnt_in;
          i_d     = 3'd0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_FIN;
        if (op_q == cnsr_pkg::OpPress && slot_ok && !held_q[slot_q]) begin
          held_d[slot_q] = 1'b1;
          if (slot_q < cfg_i.degree_count) begin
            tc_d[slot_q] = cnt_q;
            if (cnt_q != 3'd0) state_d = S_PRD;
          end
        end else if (op_q == cnsr_pkg::OpRelease && slot_ok && held_q[slot_q]) begin
          held_d[slot_q] = 1'b0;
          cnt_d          = tc_q[slot_q];
          tc_d[slot_q]   = 3'd0;
          if (tc_q[slot_q] != 3'd0) state_d = S_NRD;
        end else if (op_q == cnsr_pkg::OpAllOff) begin
          held_d = 7'd0;
          for (int s = 0; s < cnsr_pkg::NumSlots; s++) tc_d[s] = 3'd0;
          a_d     = 8'd0;
          p_d     = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_PRD: begin
        c_re    = 1'b1;
        c_ra    = note_c;
        state_d = S_PWR;
      end
      S_PWR: begin
        if (!blocked) begin
          c_we = 1'b1;
          c_wa = note_c;
          c_wd = (crd_q == cnsr_pkg::ClaimMax) ? crd_q : crd_q + 6'd1;
          s_we = 1'b1;
          s_wa = sn_base + {3'd0, i_q};
          s_wd = note_c;
          i_d  = i_q + 3'd1;
          state_d = (i_q + 3'd1 == cnt_q) ? S_FIN : S_PRD;
        end
      end
      S_NRD: begin
        s_re    = 1'b1;
        s_ra    = sn_base + {3'd0, i_q};
        state_d = S_RRD;
      end
      S_RRD: begin
        c_re    = 1'b1;
        c_ra    = srd_q;
        state_d = S_RWR;
      end
      S_RWR: begin
        if (!blocked) begin
          c_we = 1'b1;
          c_wa = srd_q;
          c_wd = dec_c;
          i_d  = i_q + 3'd1;
          state_d = (i_q + 3'd1 == cnt_q) ? S_FIN : S_NRD;
        end
      end
      S_SCAN: begin
        // read runs one address ahead of the clearing write
        if (!blocked) begin
          if (p_q) begin
            c_we = 1'b1;
            c_wa = a_q[6:0] - 7'd1;
          end
          if (a_q[7]) begin
            p_d     = 1'b0;
            state_d = S_FIN;
          end else begin
            c_re = 1'b1;
            c_ra = a_q[6:0];
            a_d  = a_q + 8'd1;
            p_d  = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          push_o.valid = 1'b1;
          if (cand_v_q) begin
            push_o.res = '{cand_k_q, cand_n_q, (cand_k_q == cnsr_pkg::EvOn) ? vel_c : 7'd0,
                           (op_q == cnsr_pkg::OpAllOff) ? 5'd1 : ch_c, mask_c, 1'b1};
          end else begin
            push_o.res = '{cnsr_pkg::EvNone, 7'd0, 7'd0, 5'd1, mask_c, 1'b1};
          end
          cand_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      a_q      <= 8'd0;
      p_q      <= 1'b0;
      held_q   <= 7'd0;
      cand_v_q <= 1'b0;
      i_q      <= 3'd0;
      cnt_q    <= 3'd0;
      for (int s = 0; s < cnsr_pkg::NumSlots; s++) tc_q[s] <= 3'd0;
    end else begin
      state_q  <= state_d;
      a_q      <= a_d;
      p_q      <= p_d;
      held_q   <= held_d;
      cand_v_q <= cand_v_d;
      i_q      <= i_d;
      cnt_q    <= cnt_d;
      tc_q     <= tc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_k_q <= cand_k_d;
    cand_n_q <= cand_n_d;
    if (in_i.valid && in_i.ready) begin
      op_q     <= in_i.opcode;
      slot_q   <= in_i.slot;
      root_q   <= root_c;
      off_q[0] <= in_i.tone_offset_0;
      off_q[1] <= in_i.tone_offset_1;
      off_q[2] <= in_i.tone_offset_2;
      off_q[3] <= in_i.tone_offset_3;
      off_q[4] <= in_i.tone_offset_4;
      off_q[5] <= in_i.tone_offset_5;
    end
  end

endmodule

// ----- rtl/cnsr_out.sv -----
`timescale 1ns / 1ps
// output register between the sequencer and the result channel
// depends on cnsr_pkg and cnsr_out_if

module cnsr_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cnsr_pkg::push_t push_i,
  output logic            free_o,
  cnsr_out_if.source      out_o
);

  logic              v_q;
  cnsr_pkg::result_t r_q;

  assign free_o = !v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (push_i.valid) begin
      v_q <= 1'b1;
    end else if (out_o.ready) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) r_q <= push_i.res;
  end

  assign out_o.valid          = v_q;
  assign out_o.event_kind     = r_q.event_kind;
  assign out_o.note_number    = r_q.note_number;
  assign out_o.event_velocity = r_q.event_velocity;
  assign out_o.event_channel  = r_q.event_channel;
  assign out_o.active_slots   = r_q.active_slots;
  assign out_o.last_result    = r_q.last_result;

endmodule

// ----- rtl/chord_slot_note_refcounter_top.sv -----
`timescale 1ns / 1ps
// chord slot note reference counter, top level with configuration registers
// depends on cnsr_pkg, the channel interfaces, cnsr_seq and cnsr_out
//
// usage: one beat on in_i is one chord slot event (press, release, all off).
// each event yields one or more result beats on out_o; the final one has
// last_result set. events with no note change give one empty result.
// configuration is written on cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// a press reads, then writes, the claim counter of each tone; a release reads the
// slot note memory, then the claim counter, then writes it, for each tone;
// all notes off sweeps the claim counter memory over all 128 notes.
// a new event is taken only after the previous one has pushed its last beat.
// after reset the claim memory is swept to zero over all 128 notes, in_i.ready
// stays low during that pass.
// a stalled receiver holds the output register; the sequencer then waits
// on the next result it has to hand over.

module chord_slot_note_refcounter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cnsr_in_if.sink    in_i,
  cnsr_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  cnsr_pkg::cfg_t  cfg_q;
  cnsr_pkg::push_t push;
  logic            out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_shift   <= 4'sd0;
      cfg_q.note_velocity  <= 7'd100;
      cfg_q.channel_number <= 5'd1;
      cfg_q.degree_count   <= 3'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cnsr_pkg::RegOctave:   cfg_q.octave_shift   <= cfg_data_i[3:0];
        cnsr_pkg::RegVelocity: cfg_q.note_velocity  <= cfg_data_i;
        cnsr_pkg::RegChannel:  cfg_q.channel_number <= cfg_data_i[4:0];
        cnsr_pkg::RegDegrees:  cfg_q.degree_count   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  cnsr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_q),
    .out_free_i (out_free),
    .push_o     (push)
  );

  cnsr_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

// ----- rtl/cnsr_chk.sv -----
`timescale 1ns / 1ps
// port level checks for the chord slot note reference counter
// depends on cnsr_pkg, bound onto chord_slot_note_refcounter_top

module cnsr_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic [6:0] note_i,
  input logic [6:0] vel_i,
  input logic       last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(note_i) && $stable(kind_i))
    else $error("stalled beat changed");

  a_on_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == cnsr_pkg::EvOn |-> vel_i != 7'd0)
    else $error("note-on with zero velocity");

  a_off_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != cnsr_pkg::EvOn |-> vel_i == 7'd0)
    else $error("velocity on non note-on");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == cnsr_pkg::EvNone |-> last_i)
    else $error("empty result not last");

endmodule

bind chord_slot_note_refcounter_top cnsr_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.event_kind),
  .note_i      (out_o.note_number),
  .vel_i       (out_o.event_velocity),
  .last_i      (out_o.last_result)
);

// ----- sim/cnsr_tb_if.sv -----
`timescale 1ns / 1ps
// note: the channel interfaces cnsr_in_if and cnsr_out_if come with the rtl
// this file only holds a small record type used by cnsr_checker

package cnsr_tb_pkg;
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [6:0] vel;
    logic [4:0] chan;
    logic [6:0] mask;
    logic       last;
  } note_event_t;
endpackage

// ----- sim/cnsr_checker.sv -----
`timescale 1ns / 1ps
// watches the event and note channels, tracks claims per note, checks note events
// depends on cnsr_pkg, cnsr_tb_pkg and the channel interfaces

module cnsr_checker import cnsr_pkg::*; import cnsr_tb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cnsr_in_if.sink    in_mon,
  cnsr_out_if.sink   out_mon,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output logic       accept_o
);

  logic [5:0]        claims [NoteRange];
  logic [6:0]        chord_notes [NumSlots][MaxTones];
  logic [2:0]        chord_size [NumSlots];
  logic [6:0]        held;
  logic signed [3:0] octave;
  logic [6:0]        velocity;
  logic [4:0]        channel;
  logic [2:0]        degrees;
  note_event_t       expected_events [$];
  int                fails = 0;

  assign fail_count_o = fails;
  assign pending_o = expected_events.size();
  assign accept_o  = (in_mon.valid && in_mon.ready) || (out_mon.valid && out_mon.ready);

  function automatic logic [4:0] sat_channel();
    if (channel < 1) return 5'd1;
    if (channel > 16) return 5'd16;
    return channel;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    fails++;
  endtask

  task automatic predict_event();
    note_event_t ev, batch [$];
    logic [6:0] mask;
    logic [1:0] op;
    int s, cnt, root, note, pc;
    logic signed [6:0] ofs [6];
    op = in_mon.opcode;
    s = in_mon.slot;
    ofs = '{in_mon.tone_offset_0, in_mon.tone_offset_1, in_mon.tone_offset_2,
            in_mon.tone_offset_3, in_mon.tone_offset_4, in_mon.tone_offset_5};
    if (op == OpPress && s < NumSlots && !held[s]) begin
      held[s] = 1'b1;
      if (s < degrees) begin
        pc = in_mon.root_pitch_class;
        root = 60 + 12 * int'(octave) + (pc <= 6 ? pc : pc - 12);
        cnt = in_mon.tone_count > MaxTones ? MaxTones : in_mon.tone_count;
        for (int i = 0; i < cnt; i++) begin
          note = root + int'(ofs[i]);
          if (note < 0) note = 0;
          if (note > 127) note = 127;
          chord_notes[s][i] = 7'(note);
          if (claims[note] == 0) begin
            ev = '{EvOn, 7'(note), (velocity == 7'd0 ? 7'd1 : velocity), sat_channel(),
                   7'd0, 1'b0};
            batch.push_back(ev);
          end
          if (claims[note] < ClaimMax) claims[note]++;
        end
        chord_size[s] = 3'(cnt);
      end
    end else if (op == OpRelease && s < NumSlots && held[s]) begin
      held[s] = 1'b0;
      for (int i = 0; i < chord_size[s]; i++) begin
        note = chord_notes[s][i];
        if (claims[note] > 0) claims[note]--;
        if (claims[note] == 0) begin
          ev = '{EvOff, 7'(note), 7'd0, sat_channel(), 7'd0, 1'b0};
          batch.push_back(ev);
        end
      end
      chord_size[s] = 3'd0;
    end else if (op == OpAllOff) begin
      for (int n = 0; n < NoteRange; n++) begin
        if (claims[n] > 0) begin
          ev = '{EvOff, 7'(n), 7'd0, 5'd1, 7'd0, 1'b0};
          batch.push_back(ev);
        end
        claims[n] = '0;
      end
      for (int k = 0; k < NumSlots; k++) chord_size[k] = 3'd0;
      held = '0;
    end
    if (batch.size() == 0) begin
      ev = '{EvNone, 7'd0, 7'd0, 5'd1, 7'd0, 1'b0};
      batch.push_back(ev);
    end
    mask = '0;
    for (int k = 0; k < NumSlots; k++) if (chord_size[k] > 0) mask[k] = 1'b1;
    foreach (batch[i]) begin
      batch[i].mask = mask;
      batch[i].last = (i == batch.size() - 1);
      expected_events.push_back(batch[i]);
    end
  endtask

  task automatic compare_event();
    note_event_t want;
    if (expected_events.size() == 0) begin
      report("unexpected beat, kind", out_mon.event_kind, -1);
      return;
    end
    want = expected_events.pop_front();
    if (out_mon.event_kind != want.kind) report("event_kind", out_mon.event_kind, want.kind);
    if (out_mon.note_number != want.note) report("note_number", out_mon.note_number, want.note);
    if (out_mon.event_velocity != want.vel)
      report("event_velocity", out_mon.event_velocity, want.vel);
    if (out_mon.event_channel != want.chan)
      report("event_channel", out_mon.event_channel, want.chan);
    if (out_mon.active_slots != want.mask)
      report("active_slots", out_mon.active_slots, want.mask);
    if (out_mon.last_result != want.last)
      report("last_result", out_mon.last_result, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NoteRange; n++) claims[n] = '0;
      for (int k = 0; k < NumSlots; k++) chord_size[k] = 3'd0;
      held = '0;
      octave = '0;
      velocity = 7'd100;
      channel = 5'd1;
      degrees = 3'd7;
      expected_events.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegOctave:   octave = cfg_data_i[3:0];
          RegVelocity: velocity = cfg_data_i;
          RegChannel:  channel = cfg_data_i[4:0];
          RegDegrees:  degrees = cfg_data_i[2:0];
          default: ;
        endcase
      end
      // compare before predicting: a new event is only taken after the last beat
      if (out_mon.valid && out_mon.ready) compare_event();
      if (in_mon.valid && in_mon.ready) predict_event();
    end
  end

endmodule

// ----- sim/chord_slot_note_refcounter_top_tb.sv -----
`timescale 1ns / 1ps
// drives chord slot events and configuration into the block, with random gaps
// depends on cnsr_pkg, the channel interfaces and cnsr_checker

module chord_slot_note_refcounter_top_tb;
  import cnsr_pkg::*;

  localparam int Limit = 20000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [6:0] cfg_data_i;
  int         fail_count;
  int         pending;
  logic       accept;
  int         quiet_cycles;
  bit         hold_off;

  cnsr_in_if  in_ch ();
  cnsr_out_if out_ch ();

  chord_slot_note_refcounter_top dut (
    .clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  cnsr_checker checker_inst (
    .clk_i, .rst_ni, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .accept_o(accept)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_done = 1'b1;
      end
      if ($urandom_range(19) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(3) != 0);
      end
    end
  end

  // watchdog on cycles with no beat accepted
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      quiet_cycles = accept ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= Limit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [2:0] s, input logic [3:0] pc,
                           input logic [2:0] cnt, input logic [41:0] ofs);
    in_ch.valid            <= 1'b1;
    in_ch.opcode           <= op;
    in_ch.slot             <= s;
    in_ch.root_pitch_class <= pc;
    in_ch.tone_count       <= cnt;
    {in_ch.tone_offset_5, in_ch.tone_offset_4, in_ch.tone_offset_3,
     in_ch.tone_offset_2, in_ch.tone_offset_1, in_ch.tone_offset_0} <= ofs;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    if ($urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
  endtask

  function automatic logic [41:0] rand_offsets(input bit wide);
    logic [41:0] v;
    for (int i = 0; i < 6; i++)
      v[i*7 +: 7] = wide ? 7'($urandom) : 7'($urandom_range(24) - 12);
    return v;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic random_run(input int count);
    logic [1:0] op;
    for (int k = 0; k < count; k++) begin
      op = ($urandom_range(19) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
      send_beat(op, ($urandom_range(15) == 0) ? 3'd7 : 3'($urandom_range(6)),
                4'($urandom), 3'($urandom), rand_offsets($urandom_range(4) == 0));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    hold_off = 0;
    cfg_we_i = 1'b0; cfg_idx_i = RegOctave; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.opcode = OpPress; in_ch.slot = '0;
    in_ch.root_pitch_class = '0; in_ch.tone_count = '0;
    {in_ch.tone_offset_5, in_ch.tone_offset_4, in_ch.tone_offset_3,
     in_ch.tone_offset_2, in_ch.tone_offset_1, in_ch.tone_offset_0} = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, repeats, overlaps, ignored slots and opcodes
    send_beat(OpPress, 0, 0, 3, {7'sd0, 7'sd0, 7'sd0, 7'sd7, 7'sd4, 7'sd0});
    send_beat(OpPress, 0, 0, 3, '0);
    send_beat(OpPress, 1, 15, 7, {7'sd48, -7'sd48, 7'sd7, 7'sd4, 7'sd0, 7'sd0});
    send_beat(OpPress, 7, 3, 2, '0);
    send_beat(2'd3, 2, 3, 2, '0);
    send_beat(OpRelease, 0, 0, 0, '0);
    send_beat(OpRelease, 0, 0, 0, '0);
    send_beat(OpPress, 6, 12, 6, {6{7'h7f}});
    send_beat(OpAllOff, 0, 0, 0, '0);
    drain();
    write_reg(RegOctave, 7'h5);
    write_reg(RegVelocity, 7'd0);
    write_reg(RegChannel, 7'd31);
    write_reg(RegDegrees, 7'd3);
    send_beat(OpPress, 2, 11, 6, {6{7'sd48}});
    send_beat(OpPress, 4, 6, 6, '0);
    send_beat(OpRelease, 4, 0, 0, '0);
    send_beat(OpRelease, 2, 0, 0, '0);
    drain();
    write_reg(RegOctave, 7'hb);
    write_reg(RegVelocity, 7'd127);
    write_reg(RegChannel, 7'd0);
    write_reg(RegDegrees, 7'd0);
    send_beat(OpPress, 3, 5, 6, {6{-7'sd48}});
    send_beat(OpRelease, 3, 0, 0, '0);
    drain();
    write_reg(RegDegrees, 7'd7);
    write_reg(RegChannel, 7'd16);

    // random, with a long receiver hold-off during the first stretch
    hold_off = 1;
    random_run(60);
    drain();
    write_reg(RegOctave, 7'($urandom_range(10) - 5));
    write_reg(RegVelocity, 7'($urandom_range(127, 1)));
    write_reg(RegChannel, 7'($urandom_range(16, 1)));
    write_reg(RegDegrees, 7'($urandom_range(7)));
    random_run(55);
    drain();
    write_reg(RegOctave, 7'd0);
    write_reg(RegVelocity, 7'd100);
    write_reg(RegChannel, 7'd1);
    write_reg(RegDegrees, 7'd7);
    random_run(55);
    drain();

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cnsr_pkg.sv
rtl/cnsr_in_if.sv
rtl/cnsr_seq.sv
rtl/cnsr_out.sv
rtl/chord_slot_note_refcounter_top.sv
rtl/cnsr_chk.sv
sim/cnsr_tb_if.sv
sim/cnsr_checker.sv
sim/chord_slot_note_refcounter_top_tb.sv
